// ===== src/lscm_pkg.sv =====
package lscm_pkg;

  localparam int unsigned NUM_ROUNDS = 12;
  localparam int unsigned BLOCK_BYTES = 16;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LOW        = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH       = 2'd1;
  localparam logic [1:0] REG_CTR_START_HIGH = 2'd2;
  localparam logic [1:0] REG_CTR_START_LOW  = 2'd3;

  localparam logic [4:0] FULL_COUNT = 5'd16;

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  valid_bytes;
    logic        first_block;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [4:0]  result_bytes;
  } out_word_t;

  // one block on its way from the front to the cipher pipeline
  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] text;
    logic [4:0]   nbytes;
  } job_t;

  // one cipher pipeline stage
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] text;
    logic [4:0]   nbytes;
  } stage_t;

  localparam logic [0:NUM_ROUNDS-1][15:0] ROUND_CONST = '{
    16'hBFFF, 16'h6E90, 16'hD16F, 16'h4137, 16'hFEC8, 16'h2FA7,
    16'h9058, 16'hD548, 16'h6AB7, 16'hBBD8, 16'h0427, 16'h947F
  };

  // L-box nibble tables: even tables feed the low byte, odd the high byte
  localparam logic [0:7][0:15][7:0] LBOX = '{
    '{8'h00,8'hFF,8'h90,8'h6F,8'h37,8'hC8,8'hA7,8'h58,
      8'h48,8'hB7,8'hD8,8'h27,8'h7F,8'h80,8'hEF,8'h10},
    '{8'h00,8'hBF,8'h6E,8'hD1,8'h41,8'hFE,8'h2F,8'h90,
      8'hD5,8'h6A,8'hBB,8'h04,8'h94,8'h2B,8'hFA,8'h45},
    '{8'h00,8'h96,8'h83,8'h15,8'hB1,8'h27,8'h32,8'hA4,
      8'h6C,8'hFA,8'hEF,8'h79,8'hDD,8'h4B,8'h5E,8'hC8},
    '{8'h00,8'h52,8'hD1,8'h83,8'hC2,8'h90,8'h13,8'h41,
      8'h49,8'h1B,8'h98,8'hCA,8'h8B,8'hD9,8'h5A,8'h08},
    '{8'h00,8'hC2,8'h24,8'hE6,8'h28,8'hEA,8'h0C,8'hCE,
      8'h56,8'h94,8'h72,8'hB0,8'h7E,8'hBC,8'h5A,8'h98},
    '{8'h00,8'h74,8'hD3,8'hA7,8'hCE,8'hBA,8'h1D,8'h69,
      8'h68,8'h1C,8'hBB,8'hCF,8'hA6,8'hD2,8'h75,8'h01},
    '{8'h00,8'h89,8'h39,8'hB0,8'h44,8'hCD,8'h7D,8'hF4,
      8'h4B,8'hC2,8'h72,8'hFB,8'h0F,8'h86,8'h36,8'hBF},
    '{8'h00,8'hE4,8'h68,8'h8C,8'h5E,8'hBA,8'h36,8'hD2,
      8'h61,8'h85,8'h09,8'hED,8'h3F,8'hDB,8'h57,8'hB3}
  };

  // big-endian counter -> cipher state (byte j of the block at bits 8j+7:8j)
  function automatic logic [127:0] ctr_to_state(input logic [127:0] c);
    logic [127:0] s;
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      s[8*j +: 8] = c[127-8*j -: 8];
    end
    return s;
  endfunction

  function automatic logic [7:0][15:0] five_box(input logic [7:0][15:0] xi);
    logic [7:0][15:0] x;
    x = xi;
    x[2] = x[2] ^ (x[0] & x[1]);
    x[1] = x[1] ^ x[2];
    x[3] = x[3] ^ (x[0] & x[4]);
    x[2] = x[2] ^ x[3];
    x[0] = x[0] ^ (x[1] & x[3]);
    x[4] = x[4] ^ x[1];
    x[1] = x[1] ^ (x[2] & x[4]);
    x[1] = x[1] ^ x[0];
    return x;
  endfunction

  function automatic logic [7:0][15:0] sbox_layer(input logic [7:0][15:0] xi);
    logic [7:0][15:0] x;
    logic [15:0] a, b, c;
    x = five_box(xi);
    x[0] = x[0] ^ x[5];
    x[1] = x[1] ^ x[6];
    x[2] = x[2] ^ x[7];
    x[3] = ~x[3];
    x[4] = ~x[4];
    a = x[5];
    b = x[6];
    c = x[7];
    x[5] = x[5] ^ (~b & c);
    x[6] = x[6] ^ (~c & a);
    x[7] = x[7] ^ (~a & b);
    x[5] = x[5] ^ x[0];
    x[6] = x[6] ^ x[1];
    x[7] = x[7] ^ x[2];
    return five_box(x);
  endfunction

  function automatic logic [15:0] lbox_row(input logic [15:0] w);
    logic [7:0] nl, nh;
    nl = LBOX[0][w[3:0]] ^ LBOX[2][w[7:4]] ^ LBOX[4][w[11:8]] ^ LBOX[6][w[15:12]];
    nh = LBOX[1][w[3:0]] ^ LBOX[3][w[7:4]] ^ LBOX[5][w[11:8]] ^ LBOX[7][w[15:12]];
    return {nh, nl};
  endfunction

  function automatic logic [127:0] cipher_round(input logic [127:0] s,
                                                input logic [15:0]  rc,
                                                input logic [127:0] key);
    logic [7:0][15:0] x;
    x = s;
    x[0] = x[0] ^ rc;
    x = sbox_layer(x);
    for (int r = 0; r < 8; r++) begin
      x[r] = lbox_row(x[r]) ^ key[16*r +: 16];
    end
    return x;
  endfunction

endpackage

// ===== src/lscm_fifo.sv =====
module lscm_fifo import lscm_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/lscm_front.sv =====
module lscm_front import lscm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  in_word_t     in_word,
  input  logic [127:0] ctr_start,
  output job_t         job,
  output logic         job_push
);

  logic [127:0] ctr_r, ctr_nxt;
  logic [127:0] ctr_use;

  // first_block reloads before this block uses the counter
  assign ctr_use = in_word.first_block ? ctr_start : ctr_r;
  assign ctr_nxt = ctr_use + 128'd1;

  assign job_push    = accept;
  assign job.ctr     = ctr_use;
  assign job.text    = {in_word.data_high, in_word.data_low};
  assign job.nbytes  = (in_word.valid_bytes > FULL_COUNT) ? FULL_COUNT : in_word.valid_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (accept) begin
      ctr_r <= ctr_nxt;
    end
  end

endmodule

// ===== src/lscm_back.sv =====
module lscm_back import lscm_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [127:0] key,
  input  logic         job_avail,
  input  job_t         job,
  output logic         job_pop,
  input  logic         res_taken,
  output logic         res_push,
  output out_word_t    res_word
);

  localparam int unsigned OW = $clog2(OUT_DEPTH + 1);

  // occupancy: words in flight plus words in the result queue
  logic [OW-1:0] occ_r, occ_nxt;
  logic [NUM_ROUNDS:0] vld_r;
  stage_t stg_r [NUM_ROUNDS+1];
  logic [127:0] ks_text, masked;

  assign job_pop = job_avail && (occ_r < OW'(OUT_DEPTH));

  always_comb begin
    occ_nxt = occ_r;
    if (job_pop && !res_taken) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!job_pop && res_taken) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      vld_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      vld_r <= {vld_r[NUM_ROUNDS-1:0], job_pop};
    end
  end

  // stage 0: key whitening
  always_ff @(posedge clk) begin
    stg_r[0].state  <= ctr_to_state(job.ctr) ^ key;
    stg_r[0].text   <= job.text;
    stg_r[0].nbytes <= job.nbytes;
  end

  for (genvar i = 1; i <= NUM_ROUNDS; i++) begin : g_round
    always_ff @(posedge clk) begin
      stg_r[i].state  <= cipher_round(stg_r[i-1].state, ROUND_CONST[i-1], key);
      stg_r[i].text   <= stg_r[i-1].text;
      stg_r[i].nbytes <= stg_r[i-1].nbytes;
    end
  end

  assign ks_text = stg_r[NUM_ROUNDS].state ^ stg_r[NUM_ROUNDS].text;

  always_comb begin
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      masked[8*j +: 8] = (5'(j) < stg_r[NUM_ROUNDS].nbytes) ? ks_text[8*j +: 8] : 8'h00;
    end
  end

  assign res_push              = vld_r[NUM_ROUNDS];
  assign res_word.result_low   = masked[63:0];
  assign res_word.result_high  = masked[127:64];
  assign res_word.result_bytes = stg_r[NUM_ROUNDS].nbytes;

endmodule

// ===== src/ls_cipher_counter_mode_top.sv =====
// Channel  | Ports                                  | Accepted when
// ---------+----------------------------------------+----------------------------
// input    | push, full, in_word (in_word_t)        | push && !full
// result   | empty, pop, out_word (out_word_t)      | pop && !empty
// config   | cfg_wr_en, cfg_index, cfg_data         | cfg_wr_en
//
// One word per cycle sustained while the result side keeps up; a word accepted reaches
// out_word through the front queue, whitening stage, 12 round stages, result queue.
// The rounds are a 13-stage pipeline: key whitening, then one round per stage.
// rst_n (sync, active low) clears the counter, config registers and queues.
// A stalled result side fills the result queue; issue into the rounds stops
// once pipeline plus result queue hold OUT_DEPTH words, then full rises.
module ls_cipher_counter_mode_top import lscm_pkg::*; #(
  parameter int unsigned MID_DEPTH = 2,  // front-to-back queue, 2 or more
  parameter int unsigned OUT_DEPTH = 16  // result queue, 2 or more
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_low_r, key_high_r, start_high_r, start_low_r;

  logic      in_accept;
  job_t      fe_job, be_job;
  logic      fe_push, mid_empty, be_pop;
  logic      res_push, res_taken;
  out_word_t res_word;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      start_high_r <= '0;
      start_low_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_LOW:        key_low_r    <= cfg_data;
        REG_KEY_HIGH:       key_high_r   <= cfg_data;
        REG_CTR_START_HIGH: start_high_r <= cfg_data;
        REG_CTR_START_LOW:  start_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_accept = push && !full;
  assign res_taken = pop && !empty;

  // front: counter bookkeeping and byte count clamp
  lscm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_word   (in_word),
    .ctr_start ({start_high_r, start_low_r}),
    .job       (fe_job),
    .job_push  (fe_push)
  );

  lscm_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_push),
    .wr_data (fe_job),
    .full    (full),
    .rd_en   (be_pop),
    .rd_data (be_job),
    .empty   (mid_empty)
  );

  // back: cipher round pipeline and keystream XOR
  lscm_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       ({key_high_r, key_low_r}),
    .job_avail (!mid_empty),
    .job       (be_job),
    .job_pop   (be_pop),
    .res_taken (res_taken),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  // credit count in the back keeps this queue from overflowing
  lscm_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

endmodule

// ===== dv/ls_cipher_counter_mode_chk.sv =====
module ls_cipher_counter_mode_chk import lscm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  in_word_t    in_word,
  input  logic        empty,
  input  logic        pop,
  input  out_word_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam logic [0:NUM_ROUNDS-1][15:0] RND_K = '{
    16'hBFFF, 16'h6E90, 16'hD16F, 16'h4137, 16'hFEC8, 16'h2FA7,
    16'h9058, 16'hD548, 16'h6AB7, 16'hBBD8, 16'h0427, 16'h947F
  };

  // nibble lookup for the row mix; even rows build the low byte
  localparam logic [0:7][0:15][7:0] NIB_MIX = '{
    '{8'h00,8'hFF,8'h90,8'h6F,8'h37,8'hC8,8'hA7,8'h58,
      8'h48,8'hB7,8'hD8,8'h27,8'h7F,8'h80,8'hEF,8'h10},
    '{8'h00,8'hBF,8'h6E,8'hD1,8'h41,8'hFE,8'h2F,8'h90,
      8'hD5,8'h6A,8'hBB,8'h04,8'h94,8'h2B,8'hFA,8'h45},
    '{8'h00,8'h96,8'h83,8'h15,8'hB1,8'h27,8'h32,8'hA4,
      8'h6C,8'hFA,8'hEF,8'h79,8'hDD,8'h4B,8'h5E,8'hC8},
    '{8'h00,8'h52,8'hD1,8'h83,8'hC2,8'h90,8'h13,8'h41,
      8'h49,8'h1B,8'h98,8'hCA,8'h8B,8'hD9,8'h5A,8'h08},
    '{8'h00,8'hC2,8'h24,8'hE6,8'h28,8'hEA,8'h0C,8'hCE,
      8'h56,8'h94,8'h72,8'hB0,8'h7E,8'hBC,8'h5A,8'h98},
    '{8'h00,8'h74,8'hD3,8'hA7,8'hCE,8'hBA,8'h1D,8'h69,
      8'h68,8'h1C,8'hBB,8'hCF,8'hA6,8'hD2,8'h75,8'h01},
    '{8'h00,8'h89,8'h39,8'hB0,8'h44,8'hCD,8'h7D,8'hF4,
      8'h4B,8'hC2,8'h72,8'hFB,8'h0F,8'h86,8'h36,8'hBF},
    '{8'h00,8'hE4,8'h68,8'h8C,8'h5E,8'hBA,8'h36,8'hD2,
      8'h61,8'h85,8'h09,8'hED,8'h3F,8'hDB,8'h57,8'hB3}
  };

  logic [127:0] key_q;
  logic [127:0] start_q;
  logic [127:0] ctr_q;
  out_word_t    crypt_q[$];
  out_word_t    want;

  // 5-bit slice of the column S-box, rows 0..4
  function automatic logic [7:0][15:0] chi5(input logic [7:0][15:0] v);
    logic [7:0][15:0] x;
    x = v;
    x[2] = x[2] ^ (x[0] & x[1]);
    x[1] = x[1] ^ x[2];
    x[3] = x[3] ^ (x[0] & x[4]);
    x[2] = x[2] ^ x[3];
    x[0] = x[0] ^ (x[1] & x[3]);
    x[4] = x[4] ^ x[1];
    x[1] = x[1] ^ (x[2] & x[4]);
    x[1] = x[1] ^ x[0];
    return x;
  endfunction

  function automatic logic [7:0][15:0] col_sub(input logic [7:0][15:0] v);
    logic [7:0][15:0] x;
    logic [15:0] a, b, c;
    x = chi5(v);
    x[0] = x[0] ^ x[5];
    x[1] = x[1] ^ x[6];
    x[2] = x[2] ^ x[7];
    x[3] = ~x[3];
    x[4] = ~x[4];
    a = x[5];
    b = x[6];
    c = x[7];
    x[5] = x[5] ^ (~b & c) ^ x[0];
    x[6] = x[6] ^ (~c & a) ^ x[1];
    x[7] = x[7] ^ (~a & b) ^ x[2];
    return chi5(x);
  endfunction

  function automatic logic [15:0] row_mix(input logic [15:0] w);
    logic [7:0] lo, hi;
    lo = NIB_MIX[0][w[3:0]] ^ NIB_MIX[2][w[7:4]] ^ NIB_MIX[4][w[11:8]] ^
         NIB_MIX[6][w[15:12]];
    hi = NIB_MIX[1][w[3:0]] ^ NIB_MIX[3][w[7:4]] ^ NIB_MIX[5][w[11:8]] ^
         NIB_MIX[7][w[15:12]];
    return {hi, lo};
  endfunction

  // encrypt one counter value; byte j of the result sits at bits 8j+7:8j
  function automatic logic [127:0] keystream(input logic [127:0] ctr,
                                             input logic [127:0] key);
    logic [7:0][15:0] s, k;
    logic [127:0] st;
    int j, i, r;
    for (j = 0; j < 16; j++) begin
      st[8*j +: 8] = ctr[127-8*j -: 8];
    end
    k = key;
    s = st ^ key;
    for (i = 0; i < NUM_ROUNDS; i++) begin
      s[0] = s[0] ^ RND_K[i];
      s = col_sub(s);
      for (r = 0; r < 8; r++) begin
        s[r] = row_mix(s[r]) ^ k[r];
      end
    end
    return s;
  endfunction

  // result of one word; also steps the counter
  function automatic out_word_t crypt_word(input in_word_t w);
    logic [127:0] ks, txt, res;
    logic [4:0] n;
    out_word_t o;
    int j;
    n = (w.valid_bytes > FULL_COUNT) ? FULL_COUNT : w.valid_bytes;
    if (w.first_block) begin
      ctr_q = start_q;
    end
    ks = keystream(ctr_q, key_q);
    txt = {w.data_high, w.data_low};
    res = '0;
    for (j = 0; j < 16; j++) begin
      if (j < n) begin
        res[8*j +: 8] = txt[8*j +: 8] ^ ks[8*j +: 8];
      end
    end
    ctr_q = ctr_q + 128'd1;
    o.result_low = res[63:0];
    o.result_high = res[127:64];
    o.result_bytes = n;
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_q = '0;
      start_q = '0;
      ctr_q = '0;
      crypt_q.delete();
    end else begin
      if (pop && !empty) begin
        if (crypt_q.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t: result word with none expected: expected nothing, actual %h",
                   $time, out_word);
        end else begin
          want = crypt_q.pop_front();
          if (out_word.result_low !== want.result_low) begin
            fail_count = fail_count + 1;
            $display("%0t: result_low expected %h actual %h",
                     $time, want.result_low, out_word.result_low);
          end
          if (out_word.result_high !== want.result_high) begin
            fail_count = fail_count + 1;
            $display("%0t: result_high expected %h actual %h",
                     $time, want.result_high, out_word.result_high);
          end
          if (out_word.result_bytes !== want.result_bytes) begin
            fail_count = fail_count + 1;
            $display("%0t: result_bytes expected %0d actual %0d",
                     $time, want.result_bytes, out_word.result_bytes);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KEY_LOW:        key_q[63:0] = cfg_data;
          REG_KEY_HIGH:       key_q[127:64] = cfg_data;
          REG_CTR_START_HIGH: start_q[127:64] = cfg_data;
          REG_CTR_START_LOW:  start_q[63:0] = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        crypt_q.push_back(crypt_word(in_word));
      end
    end
    pending = crypt_q.size();
  end

endmodule

// ===== dv/ls_cipher_counter_mode_top_test.sv =====
module ls_cipher_counter_mode_top_test;
  import lscm_pkg::*;

  // settle window after the last result
  localparam int SETTLE_CYCLES = 32;
  // keep lots of margin over the whole run
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PER_PHASE = 162;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_word_t    in_word = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_word_t   out_word;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int words_sent = 0;
  int settings_cnt = 0;
  int send_idle = 0;   // percent of cycles the sender holds off
  int recv_stall = 0;  // percent of cycles the receiver withholds pop

  always #5 clk = ~clk;

  ls_cipher_counter_mode_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // scoreboard sits on the same wires as the DUT
  ls_cipher_counter_mode_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_word    (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: pop drawn fresh every cycle; pop on empty is harmless
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_word_t mk_word(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [4:0] nb, input logic fb);
    in_word_t w;
    w.data_low = lo;
    w.data_high = hi;
    w.valid_bytes = nb;
    w.first_block = fb;
    return w;
  endfunction

  // Present one word and hold it until taken. full only moves at the rising
  // edge, so its value at the falling edge tells whether the next edge takes
  // the word. Afterwards the sender may sit idle for a random stretch.
  task automatic send(input in_word_t w);
    logic taken;
    push <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    words_sent++;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      in_word <= mk_word(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom));
      @(posedge clk);
    end
  endtask

  // stop pushing and wait until every expected word has come back
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // write all four registers; only called with the block idle
  task automatic load_settings(input logic [63:0] klo, input logic [63:0] khi,
                               input logic [63:0] chi, input logic [63:0] clo);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data  <= klo;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data  <= khi;
    @(posedge clk);
    cfg_index <= REG_CTR_START_HIGH;
    cfg_data  <= chi;
    @(posedge clk);
    cfg_index <= REG_CTR_START_LOW;
    cfg_data  <= clo;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_cnt++;
  endtask

  initial begin
    int ph, got, len, k;
    logic [4:0] nb;
    logic [63:0] clo;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset settings, no first block yet: counter runs from zero
    send(mk_word('0, '0, FULL_COUNT, 1'b0));
    send(mk_word('1, '1, FULL_COUNT, 1'b0));
    // zero count, saturated counts, short blocks around the half boundary
    send(mk_word(rand64(), rand64(), 5'd0, 1'b0));
    send(mk_word(rand64(), rand64(), 5'd31, 1'b0));
    send(mk_word(rand64(), rand64(), 5'd17, 1'b0));
    send(mk_word(rand64(), rand64(), 5'd1, 1'b0));
    send(mk_word(rand64(), rand64(), 5'd8, 1'b0));
    send(mk_word(rand64(), rand64(), 5'd9, 1'b0));
    send(mk_word(rand64(), rand64(), 5'd15, 1'b0));
    drain();

    // all-ones key and counter: second word wraps the full 128 bits
    load_settings('1, '1, '1, '1);
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b1));
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b0));
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b0));
    drain();

    // low half at the top: carry crosses into the high half, then reloads
    load_settings(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                  64'h0000_0000_0000_0005, '1);
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b1));
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b0));
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b1));
    // zero count still steps the counter
    send(mk_word(rand64(), rand64(), 5'd0, 1'b1));
    send(mk_word(rand64(), rand64(), FULL_COUNT, 1'b0));
    drain();

    load_settings({16{4'h5}}, {16{4'hA}}, '0, '0);
    send(mk_word({16{4'hA}}, {16{4'h5}}, FULL_COUNT, 1'b1));
    send(mk_word({16{4'h5}}, {16{4'hA}}, FULL_COUNT, 1'b0));
    drain();

    // --- random: one phase per idle profile ---
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      // one phase starts the counter 16 below the low-half wrap
      clo = (ph == 2) ? 64'hFFFF_FFFF_FFFF_FFF0 : rand64();
      load_settings(rand64(), rand64(), rand64(), clo);
      @(posedge clk);
      got = 0;
      while (got < RAND_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          // message: first word reloads, full words, last one maybe short
          len = $urandom_range(1, 10);
          for (k = 0; k < len; k++) begin
            nb = (k == len - 1) ? 5'($urandom_range(1, 16)) : FULL_COUNT;
            send(mk_word(rand64(), rand64(), nb, k == 0));
          end
          got += len;
        end else begin
          // noise: any count 0..31, reload at random
          send(mk_word(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom)));
          got++;
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d words over %0d key/counter settings in %0d cycles,",
             words_sent, settings_cnt, cycle_cnt);
    $display("with free-running, sender-idle, receiver-stall and mixed phases.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
